[rtl/core/ethernet_header_parser_assert.svh]
// assertion macros for the ethernet header parser
// expects clk and rst in the scope of use
`ifndef ETHERNET_HEADER_PARSER_ASSERT_SVH
`define ETHERNET_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define EHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/ehp_pkg.sv]
// ethernet header parser package
// record kinds, frame classes and header constants; no dependencies
package ehp_pkg;

  localparam int HdrKeep = 58;

  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_ARP  = 16'h0806;
  localparam logic [15:0] ET_IPV6 = 16'h86DD;
  localparam logic [7:0]  PR_ICMP  = 8'd1;
  localparam logic [7:0]  PR_TCP   = 8'd6;
  localparam logic [7:0]  PR_UDP   = 8'd17;
  localparam logic [7:0]  PR_ICMP6 = 8'd58;

  localparam logic [3:0] KIND_SUMMARY = 4'd0;
  localparam logic [3:0] KIND_DST_MAC = 4'd1;
  localparam logic [3:0] KIND_SRC_MAC = 4'd2;
  localparam logic [3:0] KIND_IPV4    = 4'd3;
  localparam logic [3:0] KIND_IP_INFO = 4'd4;
  localparam logic [3:0] KIND_L4      = 4'd5;
  localparam logic [3:0] KIND_ARP     = 4'd6;
  localparam logic [3:0] KIND_SRC_HI  = 4'd7;
  localparam logic [3:0] KIND_SRC_LO  = 4'd8;
  localparam logic [3:0] KIND_DST_HI  = 4'd9;
  localparam logic [3:0] KIND_DST_LO  = 4'd10;

  localparam logic [3:0] CLS_RUNT       = 4'd0;
  localparam logic [3:0] CLS_IPV4_SHORT = 4'd1;
  localparam logic [3:0] CLS_IPV4_UDP   = 4'd2;
  localparam logic [3:0] CLS_IPV4_TCP   = 4'd3;
  localparam logic [3:0] CLS_IPV4_ICMP  = 4'd4;
  localparam logic [3:0] CLS_IPV4_OTHER = 4'd5;
  localparam logic [3:0] CLS_ARP_SHORT  = 4'd6;
  localparam logic [3:0] CLS_ARP_REQ    = 4'd7;
  localparam logic [3:0] CLS_ARP_REPLY  = 4'd8;
  localparam logic [3:0] CLS_IPV6_SHORT = 4'd9;
  localparam logic [3:0] CLS_IPV6_UDP   = 4'd10;
  localparam logic [3:0] CLS_IPV6_TCP   = 4'd11;
  localparam logic [3:0] CLS_ICMPV6     = 4'd12;
  localparam logic [3:0] CLS_IPV6_OTHER = 4'd13;
  localparam logic [3:0] CLS_UNKNOWN    = 4'd14;

  localparam int MaxRec = 9;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
  } rec_t;

endpackage

[rtl/core/ehp_if.sv]
// channel interfaces of the ethernet header parser
// byte request channel and record channel; no dependencies
interface ehp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;
  logic       bad_crc;
  modport source (output valid, data_byte, frame_end, bad_crc, input ready);
  modport sink (input valid, data_byte, frame_end, bad_crc, output ready);
endinterface

interface ehp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  record_kind;
  logic [63:0] record_value;
  logic [3:0]  frame_class;
  logic        crc_flag;
  logic        last_record;
  modport source (output valid, record_kind, record_value, frame_class, crc_flag,
                  last_record, input ready);
  modport sink (input valid, record_kind, record_value, frame_class, crc_flag,
                last_record, output ready);
endinterface

[rtl/core/ethernet_header_parser.sv]
// ethernet header parser top level
// depends on ehp_pkg, ehp_if.sv and ethernet_header_parser_assert.svh
//
//  channel  | dir | payload
//  in_ch    | in  | data_byte, frame_end, bad_crc
//  out_ch   | out | record_kind, record_value, frame_class, crc_flag, last_record
//
// one byte per cycle; header bytes are caught at fixed places as they arrive
// decode after the last byte once the buffer is free; one record per ready cycle
// the input stalls only while a finished frame waits for the record buffer
// synchronous reset clears counters and handshake state, no clearing pass
`include "ethernet_header_parser_assert.svh"

module ethernet_header_parser
  import ehp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  ehp_in_if.sink   in_ch,
  ehp_out_if.source out_ch
);

  logic [7:0]  hdr [HdrKeep];
  logic [7:0]  l4b [4];
  logic [15:0] cnt;
  logic [15:0] len;
  logic [15:0] len_r;
  logic        crc_r;
  logic        end_pend;
  logic        busy;
  logic [3:0]  idx;
  logic [3:0]  nrec;
  logic [3:0]  cls_r;
  logic        crcf_r;
  rec_t        slot [MaxRec];

  logic        in_acc;
  logic        out_acc;
  logic        load;
  logic [3:0]  ihl_nib;
  logic [15:0] l4pos;
  logic [15:0] l4diff;

  logic [7:0]  hm [HdrKeep];
  logic [7:0]  lm [4];
  rec_t        dslot [MaxRec];
  logic [3:0]  dn;
  logic [3:0]  dcls;
  logic        dcrc;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign load    = end_pend && !busy;
  assign in_ch.ready = !(end_pend && busy);

  assign len     = (cnt == 16'hFFFF) ? 16'hFFFF : cnt + 16'd1;
  assign ihl_nib = (cnt == 16'd14) ? in_ch.data_byte[3:0] : hdr[14][3:0];
  assign l4pos   = 16'd14 + {10'd0, ihl_nib, 2'b00};
  assign l4diff  = cnt - l4pos;

  // byte capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < HdrKeep; i++) begin
        if (cnt == 16'(i)) hdr[i] <= in_ch.data_byte;
      end
      if (cnt >= l4pos && l4diff < 16'd4) l4b[l4diff[1:0]] <= in_ch.data_byte;
      len_r <= len;
      crc_r <= in_ch.bad_crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      end_pend <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_ch.frame_end) begin
          cnt <= '0;
        end else if (cnt != 16'hFFFF) begin
          cnt <= cnt + 16'd1;
        end
      end
      if (in_acc && in_ch.frame_end) begin
        end_pend <= 1'b1;
      end else if (load) begin
        end_pend <= 1'b0;
      end
    end
  end

  // decode
  always_comb begin
    logic [5:0]  ihl4;
    logic [15:0] tot;
    logic [16:0] l4p;
    logic [15:0] etype;
    logic [7:0]  proto;
    for (int i = 0; i < HdrKeep; i++) begin
      hm[i] = (16'(i) < len_r) ? hdr[i] : 8'd0;
    end
    ihl4  = {hm[14][3:0], 2'b00};
    tot   = {hm[16], hm[17]};
    l4p   = 17'd14 + {11'd0, ihl4};
    etype = {hm[12], hm[13]};
    for (int k = 0; k < 4; k++) begin
      lm[k] = ((l4p + 17'(k)) < {1'b0, len_r}) ? l4b[k] : 8'd0;
    end
    for (int i = 0; i < MaxRec; i++) begin
      dslot[i] = '0;
    end
    dslot[0] = '{KIND_SUMMARY, {32'd0, len_r, etype}};
    dslot[1] = '{KIND_DST_MAC, {16'd0, hm[0], hm[1], hm[2], hm[3], hm[4], hm[5]}};
    dslot[2] = '{KIND_SRC_MAC, {16'd0, hm[6], hm[7], hm[8], hm[9], hm[10], hm[11]}};
    dcrc  = crc_r;
    dn    = 4'd3;
    dcls  = CLS_UNKNOWN;
    proto = hm[23];
    if (len_r < 16'd14) begin
      dn   = 4'd1;
      dcls = CLS_RUNT;
      dcrc = 1'b0;
    end else if (etype == ET_IPV4) begin
      if (len_r < 16'd34) begin
        dcls = CLS_IPV4_SHORT;
        dcrc = 1'b0;
      end else begin
        dslot[3] = '{KIND_IPV4, {hm[26], hm[27], hm[28], hm[29],
                                 hm[30], hm[31], hm[32], hm[33]}};
        dslot[4] = '{KIND_IP_INFO, {48'd0, hm[22], proto}};
        dslot[5] = '{KIND_L4, {32'd0, lm[0], lm[1], lm[2], lm[3]}};
        dn = 4'd6;
        if (proto == PR_UDP && {1'b0, tot} >= {11'd0, ihl4} + 17'd8) begin
          dcls = CLS_IPV4_UDP;
        end else if (proto == PR_TCP && {1'b0, tot} >= {11'd0, ihl4} + 17'd20) begin
          dcls = CLS_IPV4_TCP;
        end else if (proto == PR_ICMP) begin
          dcls = CLS_IPV4_ICMP;
          dslot[5].value = {48'd0, lm[0], lm[1]};
        end else begin
          dcls = CLS_IPV4_OTHER;
          dn   = 4'd5;
        end
      end
    end else if (etype == ET_ARP) begin
      if (len_r >= 16'd42) begin
        dcls = ({hm[20], hm[21]} == 16'd1) ? CLS_ARP_REQ : CLS_ARP_REPLY;
        dslot[3] = '{KIND_ARP, {hm[28], hm[29], hm[30], hm[31],
                                hm[38], hm[39], hm[40], hm[41]}};
        dn = 4'd4;
      end else begin
        dcls = CLS_ARP_SHORT;
      end
    end else if (etype == ET_IPV6) begin
      if (len_r < 16'd54) begin
        dcls = CLS_IPV6_SHORT;
        dcrc = 1'b0;
      end else begin
        proto = hm[20];
        dslot[3] = '{KIND_SRC_HI, {hm[22], hm[23], hm[24], hm[25],
                                   hm[26], hm[27], hm[28], hm[29]}};
        dslot[4] = '{KIND_SRC_LO, {hm[30], hm[31], hm[32], hm[33],
                                   hm[34], hm[35], hm[36], hm[37]}};
        dslot[5] = '{KIND_DST_HI, {hm[38], hm[39], hm[40], hm[41],
                                   hm[42], hm[43], hm[44], hm[45]}};
        dslot[6] = '{KIND_DST_LO, {hm[46], hm[47], hm[48], hm[49],
                                   hm[50], hm[51], hm[52], hm[53]}};
        dslot[7] = '{KIND_IP_INFO, {56'd0, proto}};
        dslot[8] = '{KIND_L4, {32'd0, hm[54], hm[55], hm[56], hm[57]}};
        dn = 4'd9;
        if (proto == PR_UDP && len_r >= 16'd62) begin
          dcls = CLS_IPV6_UDP;
        end else if (proto == PR_ICMP6) begin
          dcls = CLS_ICMPV6;
          dslot[8].value = {48'd0, hm[54], hm[55]};
        end else if (proto == PR_TCP) begin
          dcls = CLS_IPV6_TCP;
        end else begin
          dcls = CLS_IPV6_OTHER;
          dn   = 4'd8;
        end
      end
    end
  end

  // record buffer
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MaxRec; i++) begin
        slot[i] <= dslot[i];
      end
      nrec   <= dn;
      cls_r  <= dcls;
      crcf_r <= dcrc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (out_acc) begin
      if (idx == nrec - 4'd1) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  assign out_ch.valid        = busy;
  assign out_ch.record_kind  = slot[idx].kind;
  assign out_ch.record_value = slot[idx].value;
  assign out_ch.frame_class  = cls_r;
  assign out_ch.crc_flag     = crcf_r;
  assign out_ch.last_record  = (idx == nrec - 4'd1);

  `EHP_ASSERT_NOW(a_idx_range, busy, idx < nrec, "record index beyond count")
  `EHP_ASSERT_NEXT(a_end_pends, in_acc && in_ch.frame_end, end_pend, "frame end lost")
  `EHP_ASSERT_NEXT(a_last_drains, out_acc && out_ch.last_record, !busy, "buffer not drained")
  `EHP_ASSERT_NOW(a_hold_input, end_pend && busy, !in_ch.ready, "byte taken while frame waits")

endmodule
